FILE: rtl/arbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine rectangle bounding box: shared definitions
// Default sizes, configuration register indexes, the corner selection
// tables and the stage enable bundle used by the product pipeline.
// ----------------------------------------------------------------------------
package arbb_pkg;

	// Default fixed-point format: Q16.16 in 32 bits.
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;

	// A saturated scaled product is clamped to +/- 2^61.
	localparam int PROD_LIMIT_EXP = 61;
	// A clamped product always fits in 63 signed bits.
	localparam int TERM_W         = 63;
	// Two products and an offset always fit in 64 signed bits.
	localparam int SUM_W          = 64;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX  = 3'd0,
		REG_COEF_XY  = 3'd1,
		REG_OFFSET_X = 3'd2,
		REG_COEF_YX  = 3'd3,
		REG_COEF_YY  = 3'd4,
		REG_OFFSET_Y = 3'd5
	} cfg_reg_t;

	// Corner k uses x edge CORNER_X[k] (0 left, 1 right) and
	// y edge CORNER_Y[k] (0 top, 1 bottom).
	localparam int CORNER_X [4] = '{0, 1, 1, 0};
	localparam int CORNER_Y [4] = '{0, 0, 1, 1};

	// Load enables for the three stages inside the product unit.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

FILE: rtl/arbb_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine rectangle bounding box: scaled product unit
// Forms floor(coef * operand / 2^FRAC_BITS), clamped to the range -2^61 - 1 to 2^61, over three
// register stages: two half-width partial products, their sum, then the
// scaling shift and clamp.
// ----------------------------------------------------------------------------
module arbb_term #(
	parameter int COORD_WIDTH = arbb_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = arbb_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  arbb_pkg::stage_en_t                   en,
	input  logic signed [COORD_WIDTH-1:0]         coef,
	input  logic signed [COORD_WIDTH-1:0]         operand,
	output logic signed [arbb_pkg::TERM_W-1:0]    term_s4,
	output logic                                  sat_s4
);
	import arbb_pkg::*;

	localparam int LO_W  = COORD_WIDTH / 2;
	localparam int HI_W  = COORD_WIDTH - LO_W;
	localparam int PPL_W = COORD_WIDTH + LO_W + 1;
	localparam int PPH_W = COORD_WIDTH + HI_W;
	localparam int PW    = 2 * COORD_WIDTH;
	localparam int EW    = (PW > 64) ? PW : 64;

	localparam logic signed [EW-1:0] LIM      = EW'(1) << PROD_LIMIT_EXP;
	localparam logic signed [EW-1:0] LIM_NEG  = -LIM;
	localparam logic signed [EW-1:0] LIM_NEG1 = -LIM - EW'(1);
	localparam logic        [EW-1:0] REM_MASK = (EW'(1) << FRAC_BITS) - EW'(1);

	logic signed [LO_W:0]       coef_lo;
	logic signed [HI_W-1:0]     coef_hi;
	logic signed [PPL_W-1:0]    pp_lo_d;
	logic signed [PPH_W-1:0]    pp_hi_d;
	logic signed [PPL_W-1:0]    pp_lo_s2;
	logic signed [PPH_W-1:0]    pp_hi_s2;
	logic signed [PW-1:0]       prod_s3;
	logic signed [EW-1:0]       prod_ext;
	logic signed [EW-1:0]       scaled;
	logic                       rem_nz;
	logic                       sat_pos;
	logic                       sat_neg;
	logic signed [TERM_W-1:0]   term_d;

	// The coefficient splits into an unsigned low half and a signed high half.
	always_comb begin
		coef_lo = $signed({1'b0, coef[LO_W-1:0]});
		coef_hi = coef[COORD_WIDTH-1:LO_W];
		pp_lo_d = operand * coef_lo;
		pp_hi_d = operand * coef_hi;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pp_lo_s2 <= pp_lo_d;
			pp_hi_s2 <= pp_hi_d;
		end
	end

	// Recombine the partial products into the exact product.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3 <= (PW'(pp_hi_s2) <<< LO_W) + PW'(pp_lo_s2);
		end
	end

	// The arithmetic shift rounds toward minus infinity. A negative product
	// saturates once its magnitude, rounded down, passes the limit.
	always_comb begin
		prod_ext = EW'(prod_s3);
		scaled   = prod_ext >>> FRAC_BITS;
		rem_nz   = |(prod_ext & REM_MASK);
		sat_pos  = scaled > LIM;
		sat_neg  = (scaled < LIM_NEG1) || ((scaled == LIM_NEG1) && !rem_nz);
		if (sat_pos) begin
			term_d = TERM_W'(LIM);
		end else if (sat_neg) begin
			term_d = TERM_W'(LIM_NEG);
		end else begin
			term_d = TERM_W'(scaled);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			term_s4 <= term_d;
			sat_s4  <= sat_pos | sat_neg;
		end
	end

endmodule

FILE: rtl/affine_rect_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine rectangle bounding box
// Maps the four corners of a rectangle through a configured 2D affine map
// and returns the axis-aligned bounding box of the result.
// ----------------------------------------------------------------------------
// The block takes one rectangle per clock while the output is not stalled;
// there is no state between rectangles, so back-to-back requests stream at
// full rate. The box passes through a seven-stage pipeline: corner forming,
// two stages of split multiplication (sixteen half-width multipliers serve
// the eight distinct products), scale and clamp, the affine sums, and a
// two-level min/max tree, followed by the output register that also forms
// the spans. Each stage holds its request on a downstream stall, and empty
// stages keep accepting. Coordinates are signed fixed point with FRAC_BITS
// fraction bits; products round toward minus infinity, and any clamped
// corner, product or sum sets saturated. The coefficient registers may be
// written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module affine_rect_bounding_box #(
	parameter int FRAC_BITS   = arbb_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = arbb_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [arbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]             cfg_data,
	// Rectangle requests.
	input  logic                               rect_valid,
	output logic                               rect_ready,
	input  logic signed [COORD_WIDTH-1:0]      rect_left,
	input  logic signed [COORD_WIDTH-1:0]      rect_top,
	input  logic signed [COORD_WIDTH-1:0]      rect_width,
	input  logic signed [COORD_WIDTH-1:0]      rect_height,
	// Bounding box results.
	output logic                               box_valid,
	input  logic                               box_ready,
	output logic signed [COORD_WIDTH-1:0]      box_left,
	output logic signed [COORD_WIDTH-1:0]      box_top,
	output logic [COORD_WIDTH-1:0]             box_width,
	output logic [COORD_WIDTH-1:0]             box_height,
	output logic                               saturated
);
	import arbb_pkg::*;

	localparam logic signed [COORD_WIDTH-1:0] CW_MAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CW_MIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]       SUM_MAX  = SUM_W'(CW_MAX_C);
	localparam logic signed [SUM_W-1:0]       SUM_MIN  = SUM_W'(CW_MIN_C);

	// Configuration registers.
	logic signed [COORD_WIDTH-1:0] coef_xx_q, coef_xy_q, offset_x_q;
	logic signed [COORD_WIDTH-1:0] coef_yx_q, coef_yy_q, offset_y_q;

	// Handshake and stage control.
	logic en1, en5, en6, en7, en_out;
	stage_en_t term_en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic box_valid_q;

	// Stage data.
	logic signed [COORD_WIDTH-1:0] pt_s1 [4];
	logic signed [COORD_WIDTH-1:0] pt_d [4];
	logic                          sat_d1;
	logic                          sat_s1, sat_s2, sat_s3, sat_s4;
	logic signed [COORD_WIDTH-1:0] coef_arr [4];
	logic signed [TERM_W-1:0]      term [8];
	logic [7:0]                    term_sat;
	logic signed [SUM_W-1:0]       sum_x [4];
	logic signed [SUM_W-1:0]       sum_y [4];
	logic signed [COORD_WIDTH-1:0] mx_d [4];
	logic signed [COORD_WIDTH-1:0] my_d [4];
	logic [3:0]                    clamp_x, clamp_y;
	logic signed [COORD_WIDTH-1:0] mx_s5 [4];
	logic signed [COORD_WIDTH-1:0] my_s5 [4];
	logic                          sat_s5;
	logic signed [COORD_WIDTH-1:0] xlo_s6 [2];
	logic signed [COORD_WIDTH-1:0] xhi_s6 [2];
	logic signed [COORD_WIDTH-1:0] ylo_s6 [2];
	logic signed [COORD_WIDTH-1:0] yhi_s6 [2];
	logic                          sat_s6;
	logic signed [COORD_WIDTH-1:0] xmin_s7, xmax_s7, ymin_s7, ymax_s7;
	logic                          sat_s7;
	logic signed [COORD_WIDTH-1:0] box_left_q, box_top_q;
	logic [COORD_WIDTH-1:0]        box_width_q, box_height_q;
	logic                          saturated_q;

	// Adds an edge to an extent, clamping to the coordinate range.
	function automatic logic signed [COORD_WIDTH:0] edge_add(
		input logic signed [COORD_WIDTH-1:0] base,
		input logic signed [COORD_WIDTH-1:0] extent
	);
		logic signed [COORD_WIDTH:0] s;
		logic signed [COORD_WIDTH:0] r;
		s = (COORD_WIDTH+1)'(base) + (COORD_WIDTH+1)'(extent);
		if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
			r = {1'b1, s[COORD_WIDTH] ? CW_MIN_C : CW_MAX_C};
		end else begin
			r = {1'b0, s[COORD_WIDTH-1:0]};
		end
		return r;
	endfunction

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q  <= COORD_WIDTH'(1) << FRAC_BITS;
			coef_xy_q  <= '0;
			offset_x_q <= '0;
			coef_yx_q  <= '0;
			coef_yy_q  <= COORD_WIDTH'(1) << FRAC_BITS;
			offset_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEF_XX:  coef_xx_q  <= cfg_data;
				REG_COEF_XY:  coef_xy_q  <= cfg_data;
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_COEF_YX:  coef_yx_q  <= cfg_data;
				REG_COEF_YY:  coef_yy_q  <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or the next stage loads too.
	always_comb begin
		en_out     = !box_valid_q || box_ready;
		en7        = !valid_s7 || en_out;
		en6        = !valid_s6 || en7;
		en5        = !valid_s5 || en6;
		term_en.s4 = !valid_s4 || en5;
		term_en.s3 = !valid_s3 || term_en.s4;
		term_en.s2 = !valid_s2 || term_en.s3;
		en1        = !valid_s1 || term_en.s2;
	end

	assign rect_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			box_valid_q <= 1'b0;
		end else begin
			if (en1)        valid_s1    <= rect_valid;
			if (term_en.s2) valid_s2    <= valid_s1;
			if (term_en.s3) valid_s3    <= valid_s2;
			if (term_en.s4) valid_s4    <= valid_s3;
			if (en5)        valid_s5    <= valid_s4;
			if (en6)        valid_s6    <= valid_s5;
			if (en7)        valid_s7    <= valid_s6;
			if (en_out)     box_valid_q <= valid_s7;
		end
	end

	// Stage 1: the left, right, top and bottom sides of the rectangle.
	always_comb begin
		logic signed [COORD_WIDTH:0] right_c;
		logic signed [COORD_WIDTH:0] bottom_c;
		right_c  = edge_add(rect_left, rect_width);
		bottom_c = edge_add(rect_top, rect_height);
		pt_d[0]  = rect_left;
		pt_d[1]  = right_c[COORD_WIDTH-1:0];
		pt_d[2]  = rect_top;
		pt_d[3]  = bottom_c[COORD_WIDTH-1:0];
		sat_d1   = right_c[COORD_WIDTH] | bottom_c[COORD_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pt_s1  <= pt_d;
			sat_s1 <= sat_d1;
		end
	end

	// Stages 2 to 4: eight scaled products. Product k uses coefficient k/2
	// (xx, xy, yx, yy); even k takes the left or top side, odd k the other.
	always_comb begin
		coef_arr[0] = coef_xx_q;
		coef_arr[1] = coef_xy_q;
		coef_arr[2] = coef_yx_q;
		coef_arr[3] = coef_yy_q;
	end

	for (genvar k = 0; k < 8; k++) begin : g_term
		localparam int CI = k / 2;
		localparam int PI = ((CI == 1) || (CI == 3)) ? 2 + (k % 2) : (k % 2);
		arbb_term #(
			.COORD_WIDTH (COORD_WIDTH),
			.FRAC_BITS   (FRAC_BITS)
		) u_term (
			.clk     (clk),
			.en      (term_en),
			.coef    (coef_arr[CI]),
			.operand (pt_s1[PI]),
			.term_s4 (term[k]),
			.sat_s4  (term_sat[k])
		);
	end

	// The saturation flag travels alongside the products.
	always_ff @(posedge clk) begin
		if (term_en.s2) sat_s2 <= sat_s1;
		if (term_en.s3) sat_s3 <= sat_s2;
		if (term_en.s4) sat_s4 <= sat_s3;
	end

	// Stage 5: affine sums for the four corners, clamped to range.
	for (genvar i = 0; i < 4; i++) begin : g_corner
		always_comb begin
			sum_x[i] = SUM_W'(term[CORNER_X[i]]) + SUM_W'(term[2 + CORNER_Y[i]])
				+ SUM_W'(offset_x_q);
			sum_y[i] = SUM_W'(term[4 + CORNER_X[i]]) + SUM_W'(term[6 + CORNER_Y[i]])
				+ SUM_W'(offset_y_q);
			clamp_x[i] = (sum_x[i] > SUM_MAX) || (sum_x[i] < SUM_MIN);
			clamp_y[i] = (sum_y[i] > SUM_MAX) || (sum_y[i] < SUM_MIN);
			if (sum_x[i] > SUM_MAX) begin
				mx_d[i] = CW_MAX_C;
			end else if (sum_x[i] < SUM_MIN) begin
				mx_d[i] = CW_MIN_C;
			end else begin
				mx_d[i] = COORD_WIDTH'(sum_x[i]);
			end
			if (sum_y[i] > SUM_MAX) begin
				my_d[i] = CW_MAX_C;
			end else if (sum_y[i] < SUM_MIN) begin
				my_d[i] = CW_MIN_C;
			end else begin
				my_d[i] = COORD_WIDTH'(sum_y[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			mx_s5  <= mx_d;
			my_s5  <= my_d;
			sat_s5 <= sat_s4 | (|term_sat) | (|clamp_x) | (|clamp_y);
		end
	end

	// Stage 6: min and max of corner pairs.
	always_ff @(posedge clk) begin
		if (en6) begin
			for (int p = 0; p < 2; p++) begin
				xlo_s6[p] <= (mx_s5[2*p+1] < mx_s5[2*p]) ? mx_s5[2*p+1] : mx_s5[2*p];
				xhi_s6[p] <= (mx_s5[2*p+1] > mx_s5[2*p]) ? mx_s5[2*p+1] : mx_s5[2*p];
				ylo_s6[p] <= (my_s5[2*p+1] < my_s5[2*p]) ? my_s5[2*p+1] : my_s5[2*p];
				yhi_s6[p] <= (my_s5[2*p+1] > my_s5[2*p]) ? my_s5[2*p+1] : my_s5[2*p];
			end
			sat_s6 <= sat_s5;
		end
	end

	// Stage 7: overall extremes.
	always_ff @(posedge clk) begin
		if (en7) begin
			xmin_s7 <= (xlo_s6[1] < xlo_s6[0]) ? xlo_s6[1] : xlo_s6[0];
			xmax_s7 <= (xhi_s6[1] > xhi_s6[0]) ? xhi_s6[1] : xhi_s6[0];
			ymin_s7 <= (ylo_s6[1] < ylo_s6[0]) ? ylo_s6[1] : ylo_s6[0];
			ymax_s7 <= (yhi_s6[1] > yhi_s6[0]) ? yhi_s6[1] : yhi_s6[0];
			sat_s7  <= sat_s6;
		end
	end

	// Output register: the box origin and its spans.
	always_ff @(posedge clk) begin
		if (en_out) begin
			box_left_q   <= xmin_s7;
			box_top_q    <= ymin_s7;
			box_width_q  <= COORD_WIDTH'(xmax_s7 - xmin_s7);
			box_height_q <= COORD_WIDTH'(ymax_s7 - ymin_s7);
			saturated_q  <= sat_s7;
		end
	end

	assign box_valid  = box_valid_q;
	assign box_left   = box_left_q;
	assign box_top    = box_top_q;
	assign box_width  = box_width_q;
	assign box_height = box_height_q;
	assign saturated  = saturated_q;

	// With the output register empty, every stage is free to load.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!box_valid_q |-> rect_ready)
		else $error("request refused while the output register is empty");

	// A finished box moves to the output when the output can load.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s7 && en_out) |=> box_valid_q)
		else $error("finished box did not reach the output");

	// A stalled final stage keeps its box.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s7 && !en_out) |=> (valid_s7 && $stable(xmin_s7) && $stable(xmax_s7)
			&& $stable(ymin_s7) && $stable(ymax_s7)))
		else $error("stalled box changed in the final stage");

	// The min/max tree never inverts an extent.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 |-> ((xmax_s7 >= xmin_s7) && (ymax_s7 >= ymin_s7)))
		else $error("box maximum below minimum");

endmodule
